@@ hw/rtl/eci_pkg.sv @@
`default_nettype none

package eci_pkg;

    // fraction bits of every fixed-point quantity
    localparam int F = 16;

    // pipeline depth, input register to output register
    localparam int N_STG = 7;

    // widths
    localparam int TW = F + 1;           // clamped progress, 0..one
    localparam int FW = F + 1;           // eased factor
    localparam int AW = F + 5;           // first multiplier, A operand
    localparam int OW = F + 3;           // shared operand / truncated product width
    localparam int RW = F + 4;           // raw factor before clamping
    localparam int VW = 32;              // value fields
    localparam int DW = VW + 1;          // end - start
    localparam int PW = VW + 3;          // scaled difference
    localparam int S_TDATA_W = 3 * VW;
    localparam int M_TDATA_W = ((FW + VW + 7) / 8) * 8;

    // constants rounded to F fraction bits, half up
    localparam longint ONE = longint'(1) << F;
    localparam longint C1  = ((longint'(170158) << (F + 1)) + 100000) / 200000;
    localparam longint C3  = C1 + ONE;
    localparam longint N1  = (longint'(121) << F) >> 4;
    localparam longint BP1 = ((longint'(4) << (F + 1)) + 11) / 22;
    localparam longint BP2 = ((longint'(8) << (F + 1)) + 11) / 22;
    localparam longint BP3 = ((longint'(10) << (F + 1)) + 11) / 22;
    localparam longint OF1 = ((longint'(6) << (F + 1)) + 11) / 22;
    localparam longint OF2 = ((longint'(9) << (F + 1)) + 11) / 22;
    localparam longint OF3 = ((longint'(21) << (F + 1)) + 22) / 44;

    // sized forms
    localparam logic signed [VW-1:0] V_ONE  = VW'(ONE);
    localparam logic [TW-1:0]        T_ONE  = TW'(ONE);
    localparam logic [TW-1:0]        T_HALF = TW'(ONE / 2);
    localparam logic [TW-1:0]        T_BP1  = TW'(BP1);
    localparam logic [TW-1:0]        T_BP2  = TW'(BP2);
    localparam logic [TW-1:0]        T_BP3  = TW'(BP3);
    localparam logic signed [AW-1:0] A_N1   = AW'(N1);
    localparam logic signed [AW-1:0] A_FOUR = AW'(4 * ONE);
    localparam logic signed [OW-1:0] O_ONE  = OW'(ONE);
    localparam logic signed [OW-1:0] O_TWO  = OW'(2 * ONE);
    localparam logic signed [OW-1:0] O_C1   = OW'(C1);
    localparam logic signed [OW-1:0] O_C3   = OW'(C3);
    localparam logic signed [OW-1:0] O_OF1  = OW'(OF1);
    localparam logic signed [OW-1:0] O_OF2  = OW'(OF2);
    localparam logic signed [OW-1:0] O_OF3  = OW'(OF3);
    localparam logic [F-1:0]         ADD1   = F'((ONE * 3) >> 2);
    localparam logic [F-1:0]         ADD2   = F'((ONE * 15) >> 4);
    localparam logic [F-1:0]         ADD3   = F'((ONE * 63) >> 6);
    localparam logic signed [RW-1:0] R_ONE  = RW'(ONE);
    localparam logic signed [RW-1:0] R_FMAX = RW'((longint'(1) << FW) - 1);
    localparam logic [FW-1:0]        F_MAX  = FW'((longint'(1) << FW) - 1);

    typedef enum logic [2:0] {
        EASE_LINEAR     = 3'd0,
        EASE_QUAD_IN    = 3'd1,
        EASE_QUAD_OUT   = 3'd2,
        EASE_QUAD_INOUT = 3'd3,
        EASE_OVERSHOOT  = 3'd4,
        EASE_BOUNCE     = 3'd5
    } t_mode;

endpackage

`default_nettype wire

@@ hw/rtl/easing_curve_interpolator.sv @@
// Throughput: one word per cycle while the output is not stalled; seven register
// stages, each with a valid bit and its own ready, so a stall at the output backs up only full stages.
// The longest path is the end-minus-start by factor multiply (33 x 18 bits).
// Reset (i_rst_n low, synchronous) clears the stage valid bits only; the
// datapath registers carry no reset. No state is kept between words.
`default_nettype none

module easing_curve_interpolator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [31:0] progress, [63:32] start_value, [95:64] end_value
    input  wire logic [eci_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // [2:0] opcode
    input  wire logic [2:0]                      i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // [16:0] eased_factor, [48:17] result_value, [55:49] zero
    output logic [eci_pkg::M_TDATA_W-1:0]        o_m_axis_tdata
);

    localparam int F  = eci_pkg::F;
    localparam int TW = eci_pkg::TW;
    localparam int FW = eci_pkg::FW;
    localparam int AW = eci_pkg::AW;
    localparam int OW = eci_pkg::OW;
    localparam int RW = eci_pkg::RW;
    localparam int VW = eci_pkg::VW;
    localparam int DW = eci_pkg::DW;
    localparam int PW = eci_pkg::PW;
    localparam int NS = eci_pkg::N_STG;

    // ------------------------------------------------------------------
    // Flow control: a stage takes a new word when it is empty or when the
    // stage after it is moving. Bubbles collapse under a stalled output.
    // ------------------------------------------------------------------
    logic [NS:1]   r_v;
    logic [NS+1:1] w_rdy;

    always_comb begin
        w_rdy[NS+1] = i_m_axis_tready;
        for (int k = NS; k >= 1; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_s_axis_tready = w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_v[1] <= i_s_axis_tvalid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clamp progress, decode the mode, form the first multiplier
    // operands and the end-minus-start difference.
    // ------------------------------------------------------------------
    logic signed [VW-1:0] w_prog, w_start, w_end;
    logic [TW-1:0]        w_t;
    logic signed [OW-1:0] w_t_o;
    logic signed [AW-1:0] w_t_a;
    eci_pkg::t_mode       w_mode;
    logic                 w_lower;
    logic [F-1:0]         w_add;
    logic signed [AW-1:0] w_a;
    logic signed [OW-1:0] w_b;

    assign w_prog  = i_s_axis_tdata[VW-1:0];
    assign w_start = i_s_axis_tdata[2*VW-1:VW];
    assign w_end   = i_s_axis_tdata[3*VW-1:2*VW];

    always_comb begin
        priority if (w_prog[VW-1]) begin
            w_t = '0;
        end else if (w_prog > eci_pkg::V_ONE) begin
            w_t = eci_pkg::T_ONE;
        end else begin
            w_t = w_prog[TW-1:0];
        end
    end

    assign w_t_o   = OW'({1'b0, w_t});
    assign w_t_a   = AW'({1'b0, w_t});
    assign w_lower = (w_t < eci_pkg::T_HALF);

    always_comb begin
        w_mode = eci_pkg::EASE_LINEAR;
        w_a    = '0;
        w_b    = '0;
        w_add  = '0;
        unique case (eci_pkg::t_mode'(i_s_axis_tuser))
            eci_pkg::EASE_QUAD_IN: begin
                w_mode = eci_pkg::EASE_QUAD_IN;
                w_a    = w_t_a;
                w_b    = w_t_o;
            end
            eci_pkg::EASE_QUAD_OUT: begin
                w_mode = eci_pkg::EASE_QUAD_OUT;
                w_a    = w_t_a;
                w_b    = eci_pkg::O_TWO - w_t_o;
            end
            eci_pkg::EASE_QUAD_INOUT: begin
                w_mode = eci_pkg::EASE_QUAD_INOUT;
                w_a    = w_lower ? (w_t_a <<< 1) : (eci_pkg::A_FOUR - (w_t_a <<< 1));
                w_b    = w_t_o;
            end
            eci_pkg::EASE_OVERSHOOT: begin
                // u = t - 1, squared first
                w_mode = eci_pkg::EASE_OVERSHOOT;
                w_b    = w_t_o - eci_pkg::O_ONE;
                w_a    = AW'(w_b);
            end
            eci_pkg::EASE_BOUNCE: begin
                // pick the bounce arc, then 7.5625 * v
                w_mode = eci_pkg::EASE_BOUNCE;
                w_a    = eci_pkg::A_N1;
                priority if (w_t < eci_pkg::T_BP1) begin
                    w_b   = w_t_o;
                    w_add = '0;
                end else if (w_t < eci_pkg::T_BP2) begin
                    w_b   = w_t_o - eci_pkg::O_OF1;
                    w_add = eci_pkg::ADD1;
                end else if (w_t < eci_pkg::T_BP3) begin
                    w_b   = w_t_o - eci_pkg::O_OF2;
                    w_add = eci_pkg::ADD2;
                end else begin
                    w_b   = w_t_o - eci_pkg::O_OF3;
                    w_add = eci_pkg::ADD3;
                end
            end
            default: begin
                // linear and the two unused codes
                w_mode = eci_pkg::EASE_LINEAR;
            end
        endcase
    end

    eci_pkg::t_mode       r_s1_mode;
    logic [TW-1:0]        r_s1_t;
    logic                 r_s1_lower;
    logic [F-1:0]         r_s1_add;
    logic signed [AW-1:0] r_s1_a;
    logic signed [OW-1:0] r_s1_b;
    logic signed [DW-1:0] r_s1_diff;
    logic signed [VW-1:0] r_s1_s;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s1_mode  <= w_mode;
            r_s1_t     <= w_t;
            r_s1_lower <= w_lower;
            r_s1_add   <= w_add;
            r_s1_a     <= w_a;
            r_s1_b     <= w_b;
            r_s1_diff  <= DW'(w_end) - DW'(w_start);
            r_s1_s     <= w_start;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: first product, floored to F fraction bits.
    // ------------------------------------------------------------------
    logic signed [AW+OW-1:0] w_p1;
    assign w_p1 = r_s1_a * r_s1_b;

    eci_pkg::t_mode       r_s2_mode;
    logic [TW-1:0]        r_s2_t;
    logic                 r_s2_lower;
    logic [F-1:0]         r_s2_add;
    logic signed [OW-1:0] r_s2_b;
    logic signed [OW-1:0] r_s2_q1;
    logic signed [DW-1:0] r_s2_diff;
    logic signed [VW-1:0] r_s2_s;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s2_mode  <= r_s1_mode;
            r_s2_t     <= r_s1_t;
            r_s2_lower <= r_s1_lower;
            r_s2_add   <= r_s1_add;
            r_s2_b     <= r_s1_b;
            r_s2_q1    <= w_p1[F+OW-1:F];
            r_s2_diff  <= r_s1_diff;
            r_s2_s     <= r_s1_s;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: out-back scales u^2 by c3 and c1; out-bounce multiplies by v.
    // ------------------------------------------------------------------
    logic signed [OW-1:0]   w_x2;
    logic signed [2*OW-1:0] w_p2, w_p3;

    assign w_x2 = (r_s2_mode == eci_pkg::EASE_OVERSHOOT) ? eci_pkg::O_C3 : r_s2_b;
    assign w_p2 = r_s2_q1 * w_x2;
    assign w_p3 = r_s2_q1 * eci_pkg::O_C1;

    eci_pkg::t_mode       r_s3_mode;
    logic [TW-1:0]        r_s3_t;
    logic                 r_s3_lower;
    logic [F-1:0]         r_s3_add;
    logic signed [OW-1:0] r_s3_b;
    logic signed [OW-1:0] r_s3_q1, r_s3_q2, r_s3_q3;
    logic signed [DW-1:0] r_s3_diff;
    logic signed [VW-1:0] r_s3_s;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_s3_mode  <= r_s2_mode;
            r_s3_t     <= r_s2_t;
            r_s3_lower <= r_s2_lower;
            r_s3_add   <= r_s2_add;
            r_s3_b     <= r_s2_b;
            r_s3_q1    <= r_s2_q1;
            r_s3_q2    <= w_p2[F+OW-1:F];
            r_s3_q3    <= w_p3[F+OW-1:F];
            r_s3_diff  <= r_s2_diff;
            r_s3_s     <= r_s2_s;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: out-back cubic term, c3 * u^2 * u.
    // ------------------------------------------------------------------
    logic signed [2*OW-1:0] w_p4;
    assign w_p4 = r_s3_q2 * r_s3_b;

    eci_pkg::t_mode       r_s4_mode;
    logic [TW-1:0]        r_s4_t;
    logic                 r_s4_lower;
    logic [F-1:0]         r_s4_add;
    logic signed [OW-1:0] r_s4_q1, r_s4_q2, r_s4_q3, r_s4_q4;
    logic signed [DW-1:0] r_s4_diff;
    logic signed [VW-1:0] r_s4_s;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_s4_mode  <= r_s3_mode;
            r_s4_t     <= r_s3_t;
            r_s4_lower <= r_s3_lower;
            r_s4_add   <= r_s3_add;
            r_s4_q1    <= r_s3_q1;
            r_s4_q2    <= r_s3_q2;
            r_s4_q3    <= r_s3_q3;
            r_s4_q4    <= w_p4[F+OW-1:F];
            r_s4_diff  <= r_s3_diff;
            r_s4_s     <= r_s3_s;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: assemble the curve value per mode and clamp to the factor range.
    // ------------------------------------------------------------------
    logic signed [RW-1:0] w_raw;
    logic [FW-1:0]        w_f;

    always_comb begin
        unique case (r_s4_mode)
            eci_pkg::EASE_QUAD_IN,
            eci_pkg::EASE_QUAD_OUT: begin
                w_raw = RW'(r_s4_q1);
            end
            eci_pkg::EASE_QUAD_INOUT: begin
                w_raw = r_s4_lower ? RW'(r_s4_q1) : (RW'(r_s4_q1) - eci_pkg::R_ONE);
            end
            eci_pkg::EASE_OVERSHOOT: begin
                w_raw = eci_pkg::R_ONE + RW'(r_s4_q4) + RW'(r_s4_q3);
            end
            eci_pkg::EASE_BOUNCE: begin
                w_raw = RW'(r_s4_q2) + RW'({1'b0, r_s4_add});
            end
            default: begin
                w_raw = RW'({1'b0, r_s4_t});
            end
        endcase
    end

    always_comb begin
        priority if (w_raw[RW-1]) begin
            w_f = '0;
        end else if (w_raw > eci_pkg::R_FMAX) begin
            w_f = eci_pkg::F_MAX;
        end else begin
            w_f = w_raw[FW-1:0];
        end
    end

    logic [FW-1:0]        r_s5_f;
    logic signed [DW-1:0] r_s5_diff;
    logic signed [VW-1:0] r_s5_s;

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_s5_f    <= w_f;
            r_s5_diff <= r_s4_diff;
            r_s5_s    <= r_s4_s;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: (end - start) * factor, floored.
    // ------------------------------------------------------------------
    logic signed [FW:0]      w_f_s;
    logic signed [DW+FW:0]   w_p6;

    assign w_f_s = {1'b0, r_s5_f};
    assign w_p6  = r_s5_diff * w_f_s;

    logic [FW-1:0]        r_s6_f;
    logic signed [PW-1:0] r_s6_p;
    logic signed [VW-1:0] r_s6_s;

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            r_s6_f <= r_s5_f;
            r_s6_p <= w_p6[F+PW-1:F];
            r_s6_s <= r_s5_s;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: add start, saturate to 32 bits; this is the output register.
    // ------------------------------------------------------------------
    logic signed [PW:0]   w_sum;
    logic signed [VW-1:0] w_res;

    assign w_sum = (PW+1)'(r_s6_s) + (PW+1)'(r_s6_p);

    always_comb begin
        // in range when every bit above the value sign bit matches it
        priority if (w_sum[PW:VW-1] == '0 || w_sum[PW:VW-1] == '1) begin
            w_res = w_sum[VW-1:0];
        end else if (w_sum[PW]) begin
            w_res = {1'b1, {(VW-1){1'b0}}};
        end else begin
            w_res = {1'b0, {(VW-1){1'b1}}};
        end
    end

    logic [FW-1:0]        r_s7_f;
    logic signed [VW-1:0] r_s7_r;

    always_ff @(posedge i_clk) begin
        if (w_rdy[7]) begin
            r_s7_f <= r_s6_f;
            r_s7_r <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_v[NS];
    assign o_m_axis_tdata  = {{(eci_pkg::M_TDATA_W-FW-VW){1'b0}}, r_s7_r, r_s7_f};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------

    // input is refused only when every stage holds a word
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (&r_v))
        else $error("input blocked while a stage is empty");

    // an accepted word lands in stage 1
    a_enter_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_v[1])
        else $error("accepted word missing from stage 1");

    // a blocked middle stage keeps its word and its data
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] && !w_rdy[5] |=> r_v[4] && $stable(r_s4_q2) && $stable(r_s4_q4))
        else $error("stage 4 word changed while blocked");

endmodule

`default_nettype wire

@@ bench/easing_curve_interpolator_tb.sv @@
`default_nettype none

module easing_curve_interpolator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = eci_pkg::F;
    localparam int FACW = eci_pkg::FW;
    localparam int VALW = eci_pkg::VW;
    localparam int RANDOM_WORDS = 1530;

    // opcodes the block leaves unnamed; both fall back to the linear curve
    localparam logic [2:0] EASE_SPARE_LO = 3'd6;
    localparam logic [2:0] EASE_SPARE_HI = 3'd7;

    localparam logic [31:0] VAL_MIN = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic [2:0]      mode;
        logic [31:0]     progress;
        logic [FACW-1:0] factor;
        logic [VALW-1:0] value;
    } t_curve_point;

    // Holds the predicted points in acceptance order and scores each output word.
    class t_easing_scoreboard;
        t_curve_point pending_points[$];
        int unsigned  mismatches;
        int unsigned  checked;

        function new();
            mismatches = 0;
            checked    = 0;
        endfunction

        // num/den with FRAC fraction bits, half rounded up
        static function longint round_frac(longint num, longint den);
            return ((num << (FRAC + 1)) + den) / (2 * den);
        endfunction

        // full-width product, low FRAC bits dropped toward minus infinity
        static function longint mul_floor(longint a, longint b);
            longint p;
            p = a * b;
            return p >>> FRAC;
        endfunction

        static function longint ease_factor(logic [2:0] mode, longint t);
            longint one;
            longint c1;
            longint u;
            longint u2;
            longint v;
            longint add;
            one = longint'(1) << FRAC;
            case (mode)
                eci_pkg::EASE_QUAD_IN: begin
                    return mul_floor(t, t);
                end
                eci_pkg::EASE_QUAD_OUT: begin
                    return mul_floor(t, 2 * one - t);
                end
                eci_pkg::EASE_QUAD_INOUT: begin
                    if (t < one / 2) begin
                        return mul_floor(2 * t, t);
                    end
                    return -one + mul_floor(4 * one - 2 * t, t);
                end
                eci_pkg::EASE_OVERSHOOT: begin
                    c1 = round_frac(170158, 100000);
                    u  = t - one;
                    u2 = mul_floor(u, u);
                    return one + mul_floor(mul_floor(c1 + one, u2), u) + mul_floor(c1, u2);
                end
                eci_pkg::EASE_BOUNCE: begin
                    // four parabolic arcs, each landing on a higher floor
                    if (t < round_frac(4, 11)) begin
                        v   = t;
                        add = 0;
                    end else if (t < round_frac(8, 11)) begin
                        v   = t - round_frac(6, 11);
                        add = (one * 3) >> 2;
                    end else if (t < round_frac(10, 11)) begin
                        v   = t - round_frac(9, 11);
                        add = (one * 15) >> 4;
                    end else begin
                        v   = t - round_frac(21, 22);
                        add = (one * 63) >> 6;
                    end
                    return mul_floor(mul_floor((longint'(121) << FRAC) >> 4, v), v) + add;
                end
                default: begin
                    return t;
                end
            endcase
        endfunction

        static function t_curve_point predict_curve_point(logic [2:0] mode,
                                                          logic [31:0] progress,
                                                          logic [31:0] start_v,
                                                          logic [31:0] end_v);
            t_curve_point pt;
            longint one;
            longint t;
            longint s;
            longint e;
            longint f;
            longint r;
            one = longint'(1) << FRAC;
            t = longint'($signed(progress));
            s = longint'($signed(start_v));
            e = longint'($signed(end_v));
            // clamp progress to 0..1
            if (t < 0) t = 0;
            if (t > one) t = one;
            // saturate the factor to its output range before it scales anything
            f = ease_factor(mode, t);
            if (f < 0) f = 0;
            if (f > (longint'(1) << FACW) - 1) f = (longint'(1) << FACW) - 1;
            r = s + mul_floor(e - s, f);
            if (r > longint'($signed(VAL_MAX))) r = longint'($signed(VAL_MAX));
            if (r < longint'($signed(VAL_MIN))) r = longint'($signed(VAL_MIN));
            pt.mode     = mode;
            pt.progress = progress;
            pt.factor   = f[FACW-1:0];
            pt.value    = r[VALW-1:0];
            return pt;
        endfunction

        function void note_input(logic [2:0] mode, logic [31:0] progress,
                                 logic [31:0] start_v, logic [31:0] end_v);
            pending_points.push_back(predict_curve_point(mode, progress, start_v, end_v));
        endfunction

        function void check_result(logic [FACW-1:0] factor, logic [VALW-1:0] value);
            t_curve_point want;
            checked++;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] unexpected output word: factor=%h value=%h",
                             $realtime, factor, value);
                end
                return;
            end
            want = pending_points.pop_front();
            if (factor !== want.factor || value !== want.value) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"[%0t] mismatch mode=%0d progress=%h: ",
                              "factor exp %h got %h, value exp %h got %h"},
                             $realtime, want.mode, want.progress, want.factor, factor,
                             want.value, value);
                end
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic [eci_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [2:0]                    s_tuser = '0;
    logic                          m_tready = 1'b0;
    wire                           s_tready;
    wire                           m_tvalid;
    wire  [eci_pkg::M_TDATA_W-1:0] m_tdata;

    t_easing_scoreboard sb = new();

    // when set, neither side inserts idle cycles
    bit          steady = 1'b0;
    int unsigned mode_seen [8];
    int unsigned words_sent = 0;

    easing_curve_interpolator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        // [31:0] progress, [63:32] start_value, [95:64] end_value
        .i_s_axis_tdata  (s_tdata),
        // [2:0] opcode
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        // [16:0] eased_factor, [48:17] result_value, [55:49] zero
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    // Pick an idle stretch: mostly none, often a few cycles, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one word after an optional gap and hold it until the block takes it.
    task automatic send_word(logic [2:0] mode, logic [31:0] progress,
                             logic [31:0] start_v, logic [31:0] end_v);
        int unsigned gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {end_v, start_v, progress};
        s_tuser  <= mode;
        forever begin
            @(posedge i_clk);
            if (s_tready) break;
        end
        sb.note_input(mode, progress, start_v, end_v);
        mode_seen[mode]++;
        words_sent++;
    endtask

    // Progress drawn to hit the whole range, the clamp edges and the curve seams.
    function automatic logic [31:0] pick_progress();
        int unsigned r;
        longint      seam [6];
        longint      p;
        seam[0] = 0;
        seam[1] = (longint'(1) << FRAC) / 2;
        seam[2] = t_easing_scoreboard::round_frac(4, 11);
        seam[3] = t_easing_scoreboard::round_frac(8, 11);
        seam[4] = t_easing_scoreboard::round_frac(10, 11);
        seam[5] = longint'(1) << FRAC;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 32'($urandom_range(0, 1 << FRAC));
        end else if (r < 70) begin
            p = seam[$urandom_range(0, 5)] + longint'($urandom_range(0, 16)) - 8;
            return p[31:0];
        end else if (r < 85) begin
            return $urandom;
        end
        // just outside the clamp on either side
        p = longint'($urandom_range(0, 1 << FRAC));
        if ($urandom_range(0, 1) == 0) p = -p;
        else p = p + (longint'(1) << FRAC);
        return p[31:0];
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 6) return $urandom;
        return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
    endfunction

    // Output side: score every accepted word, then pick next cycle's ready.
    initial begin : drain_results
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tready && m_tvalid) begin
                sb.check_result(m_tdata[FACW-1:0], m_tdata[FACW+VALW-1:FACW]);
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (!steady && $urandom_range(0, 99) < 30) begin
                hold = idle_len();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        longint one;
        longint bp1;
        longint bp2;
        longint bp3;
        one = longint'(1) << FRAC;
        bp1 = t_easing_scoreboard::round_frac(4, 11);
        bp2 = t_easing_scoreboard::round_frac(8, 11);
        bp3 = t_easing_scoreboard::round_frac(10, 11);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // linear: clamp below and above, the extremes of progress
        send_word(eci_pkg::EASE_LINEAR, 32'hFFFF_FFFF, 32'hFFFB_0000, 32'h0007_0000);
        send_word(eci_pkg::EASE_LINEAR, 32'h0000_8000, 32'hFFFB_0000, 32'h0007_0000);
        send_word(eci_pkg::EASE_LINEAR, 32'h0002_0000, 32'hFFFB_0000, 32'h0007_0000);
        send_word(eci_pkg::EASE_LINEAR, VAL_MIN, VAL_MAX, VAL_MIN);
        send_word(eci_pkg::EASE_LINEAR, VAL_MAX, VAL_MIN, VAL_MAX);
        // quadratic curves around the midpoint and the in-out seam
        send_word(eci_pkg::EASE_QUAD_IN, 32'h0000_8000, 32'h0000_0000, 32'h0001_0000);
        send_word(eci_pkg::EASE_QUAD_IN, 32'h0000_4000, VAL_MAX, VAL_MIN);
        send_word(eci_pkg::EASE_QUAD_OUT, 32'h0000_8000, 32'h0000_0000, 32'h0001_0000);
        send_word(eci_pkg::EASE_QUAD_OUT, 32'h0000_4000, VAL_MIN, VAL_MAX);
        send_word(eci_pkg::EASE_QUAD_INOUT, 32'h0000_7FFF, 32'h0000_0000, 32'h0001_0000);
        send_word(eci_pkg::EASE_QUAD_INOUT, 32'h0000_8000, 32'h0000_0000, 32'h0001_0000);
        // out-back overshoot drives the result past both rails
        send_word(eci_pkg::EASE_OVERSHOOT, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        send_word(eci_pkg::EASE_OVERSHOOT, 32'h0000_A000, VAL_MIN, VAL_MAX);
        send_word(eci_pkg::EASE_OVERSHOOT, 32'h0000_A000, VAL_MAX, VAL_MIN);
        send_word(eci_pkg::EASE_OVERSHOOT, 32'h0001_0000, VAL_MIN, VAL_MAX);
        // out-bounce on both sides of each arc boundary
        send_word(eci_pkg::EASE_BOUNCE, 32'(bp1 - 1), 32'h0000_0000, 32'h0001_0000);
        send_word(eci_pkg::EASE_BOUNCE, 32'(bp1), 32'h0000_0000, 32'h0001_0000);
        send_word(eci_pkg::EASE_BOUNCE, 32'(bp2 - 1), 32'h0000_0000, 32'h0001_0000);
        send_word(eci_pkg::EASE_BOUNCE, 32'(bp2), 32'h0000_0000, 32'h0001_0000);
        send_word(eci_pkg::EASE_BOUNCE, 32'(bp3 - 1), 32'h0000_0000, 32'h0001_0000);
        send_word(eci_pkg::EASE_BOUNCE, 32'(bp3), 32'h0000_0000, 32'h0001_0000);
        send_word(eci_pkg::EASE_BOUNCE, 32'(one), VAL_MIN, VAL_MAX);
        // unnamed opcodes fall back to linear
        send_word(EASE_SPARE_LO, 32'h0000_8000, 32'hFFFB_0000, 32'h0007_0000);
        send_word(EASE_SPARE_HI, 32'h0000_C000, VAL_MAX, VAL_MIN);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // alternate gapped traffic with back-to-back bursts
            if (n % 250 == 0) steady = ($urandom_range(0, 2) == 0);
            send_word(3'($urandom_range(0, 7)), pick_progress(), pick_value(), pick_value());
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        // drain, then give the pipeline a margin for any stray word
        while (sb.pending_points.size() != 0) @(posedge i_clk);
        repeat (3 * eci_pkg::N_STG) @(posedge i_clk);

        $display("Sent %0d words, scored %0d outputs, %0d mismatches, %0d left unanswered.",
                 words_sent, sb.checked, sb.mismatches, sb.pending_points.size());
        $display("Words per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3],
                 mode_seen[4], mode_seen[5], mode_seen[6], mode_seen[7]);
        if (sb.mismatches == 0 && sb.pending_points.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
